// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is held.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/nic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nic_pkg;

  // Table geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_BYTES = 10;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int KLO_W  = 64;
  localparam int KHI_W  = 16;
  localparam int TIME_W = 32;
  localparam int UIDX_W = 16;
  localparam int STAT_W = 3;

  // Only the first KEY_BYTES bytes of the key take part
  localparam logic [KLO_W-1:0] KEY_LOW_MASK =
    (KEY_BYTES >= 8) ? {KLO_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [KHI_W-1:0] KEY_HIGH_MASK =
    (KEY_BYTES >= 10) ? 16'hFFFF : ((KEY_BYTES == 9) ? 16'h00FF : 16'h0000);

  localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd60000;

  // Request types
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } nic_state_t;

  // One stored entry
  typedef struct packed {
    logic [KLO_W-1:0]  key_low;
    logic [KHI_W-1:0]  key_high;
    logic [UIDX_W-1:0] user_index;
    logic [TIME_W-1:0] stamp;
  } nic_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic load_out;
  } nic_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } nic_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nic_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface nic_in_if import nic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KLO_W-1:0]  key_low;
  logic [KHI_W-1:0]  key_high;
  logic [TIME_W-1:0] now_ms;
  logic              dir_found;
  logic [UIDX_W-1:0] dir_index;

  modport source (output valid, req_type, key_low, key_high, now_ms, dir_found, dir_index,
                  input ready);
  modport sink (input valid, req_type, key_low, key_high, now_ms, dir_found, dir_index,
                output ready);
endinterface

// Result channel
interface nic_out_if import nic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [UIDX_W-1:0] user_index;

  modport source (output valid, status, user_index, input ready);
  modport sink (input valid, status, user_index, output ready);
endinterface

// Timeout register write channel
interface nic_cfg_if import nic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nic_ctrl import nic_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire nic_sts_t sts,
  output nic_cmd_t      cmd
);

  nic_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nic_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nic_dp import nic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nic_cmd_t          cmd,
  output nic_sts_t               sts,
  // request payload
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [KLO_W-1:0]  in_key_low,
  input  wire logic [KHI_W-1:0]  in_key_high,
  input  wire logic [TIME_W-1:0] in_now_ms,
  input  wire logic              in_dir_found,
  input  wire logic [UIDX_W-1:0] in_dir_index,
  // timeout register write
  input  wire logic              cfg_valid,
  input  wire logic [TIME_W-1:0] cfg_data,
  // result
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [UIDX_W-1:0]      out_user_index
);

  // Captured request
  logic [REQ_W-1:0]  req_type_r;
  logic [KLO_W-1:0]  key_low_r;
  logic [KHI_W-1:0]  key_high_r;
  logic [TIME_W-1:0] now_r;
  logic              dir_found_r;
  logic [UIDX_W-1:0] dir_index_r;

  logic [TIME_W-1:0] expiry_r;

  // Entry storage and per-entry valid bits
  nic_entry_t        mem [ENTRIES];
  nic_entry_t        rd_data_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;

  // Scan sequencing
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_vld_r, rd_vld_nxt;

  // Scan results
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [UIDX_W-1:0] hit_uidx_r, hit_uidx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]  free_dist_r, free_dist_nxt;

  // Compare stage
  logic              cur_valid;
  logic              key_match;
  logic [TIME_W-1:0] age;
  logic [IDX_W:0]    gap_raw;
  logic [IDX_W-1:0]  slot_gap;

  // Memory write port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  nic_entry_t        mem_wd;

  // Result
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, res_status;
  logic [UIDX_W-1:0] out_uidx_r, res_uidx;

  // Request capture, keys masked to KEY_BYTES
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type_r  <= in_req_type;
      key_low_r   <= in_key_low & KEY_LOW_MASK;
      key_high_r  <= in_key_high & KEY_HIGH_MASK;
      now_r       <= in_now_ms;
      dir_found_r <= in_dir_found;
      dir_index_r <= in_dir_index;
    end
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else if (cfg_valid) begin
      expiry_r <= cfg_data;
    end
  end

  // Read address issue: one entry per cycle
  always_comb begin
    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    rd_addr    = cnt_r[IDX_W-1:0];
    if (cmd.start) begin
      cnt_nxt = '0;
    end else if (cmd.scan && (cnt_r < CNT_W'(ENTRIES))) begin
      cnt_nxt    = cnt_r + CNT_W'(1);
      rd_vld_nxt = 1'b1;
    end
  end

  // Memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  // Compare on the entry read last cycle
  assign cur_valid = valid_r[rd_idx_r];
  assign key_match = cur_valid && (rd_data_r.key_low == key_low_r)
                     && (rd_data_r.key_high == key_high_r);
  assign age       = now_r - rd_data_r.stamp;

  // Distance of a slot from the one after the insert pointer, wrapped
  assign gap_raw  = {1'b0, rd_idx_r} + (IDX_W+1)'(ENTRIES - 1) - {1'b0, ptr_r};
  assign slot_gap = (gap_raw >= (IDX_W+1)'(ENTRIES))
                    ? IDX_W'(gap_raw - (IDX_W+1)'(ENTRIES)) : gap_raw[IDX_W-1:0];

  assign sts.scan_done = rd_vld_r && (rd_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Scan bookkeeping and commit
  always_comb begin
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_uidx_nxt   = hit_uidx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    free_dist_nxt  = free_dist_r;
    valid_nxt      = valid_r;
    ptr_nxt        = ptr_r;
    mem_we         = 1'b0;
    mem_wa         = hit_idx_r;
    mem_wd         = '{key_low: key_low_r, key_high: key_high_r,
                       user_index: hit_uidx_r, stamp: now_r};
    if (cmd.start) begin
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
    end else if (rd_vld_r) begin
      // lowest matching slot wins
      if (key_match && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = rd_idx_r;
        hit_uidx_nxt = rd_data_r.user_index;
      end
      // first free slot after the insert pointer
      if (!cur_valid && (!free_found_r || (slot_gap < free_dist_r))) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
        free_dist_nxt  = slot_gap;
      end
      // sweep clears stale entries as they go by
      if ((req_type_r == REQ_EXPIRE) && cur_valid && (age > expiry_r)) begin
        valid_nxt[rd_idx_r] = 1'b0;
      end
    end else if (cmd.commit) begin
      case (req_type_r)
        REQ_ADD: begin
          if (hit_r) begin
            // refresh time stamp
            mem_we = 1'b1;
          end else if (dir_found_r && free_found_r) begin
            mem_we            = 1'b1;
            mem_wa            = free_idx_r;
            mem_wd.user_index = dir_index_r;
            valid_nxt[free_idx_r] = 1'b1;
            ptr_nxt = (ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : ptr_r + IDX_W'(1);
          end
        end
        REQ_DELETE: begin
          if (hit_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control and scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      ptr_r        <= '0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      ptr_r        <= ptr_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    hit_uidx_r  <= hit_uidx_nxt;
    free_idx_r  <= free_idx_nxt;
    free_dist_r <= free_dist_nxt;
  end

  // Result selection
  always_comb begin
    res_status = STAT_DONE;
    res_uidx   = '0;
    if (req_type_r == REQ_ADD) begin
      if (hit_r) begin
        res_status = STAT_HIT;
        res_uidx   = hit_uidx_r;
      end else if (!dir_found_r) begin
        res_status = STAT_NOT_FOUND;
      end else if (free_found_r) begin
        res_status = STAT_INSERTED;
        res_uidx   = dir_index_r;
      end else begin
        res_status = STAT_FULL;
        res_uidx   = dir_index_r;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status;
      out_uidx_r   <= res_uidx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_user_index = out_uidx_r;

endmodule

`default_nettype wire

// ===== hw/rtl/name_index_cache_with_expiry.sv =====
// Name index cache with expiry.
// in_req (sink): one request per handshake: add/look up, delete by key, or
//   expiry sweep, with the key, the current millisecond tick and the
//   directory answer used when an add misses.
// out_res (source): exactly one result per request, status and user index.
// cfg_wr (sink): writes the expiry timeout in ms; always ready, write only
//   while no request is in flight.
// Every request walks all 16 entries through the single read port of the
//   entry memory, one entry a cycle, then commits at most one write. A new
//   request is accepted only once the last result is in the output register.
// A finished result waits in the output register; the next request is
//   accepted meanwhile and holds in its last step until the register frees.
// Reset: all entries invalid, insert pointer zero, timeout 60000 ms,
//   no result pending. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module name_index_cache_with_expiry import nic_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  nic_in_if.sink   in_req,
  nic_out_if.source out_res,
  nic_cfg_if.sink  cfg_wr
);

  nic_cmd_t cmd;
  nic_sts_t sts;
  logic     in_ready;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  // Sequencer
  nic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, scan and result datapath
  nic_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req.req_type),
    .in_key_low     (in_req.key_low),
    .in_key_high    (in_req.key_high),
    .in_now_ms      (in_req.now_ms),
    .in_dir_found   (in_req.dir_found),
    .in_dir_index   (in_req.dir_index),
    .cfg_valid      (cfg_wr.valid),
    .cfg_data       (cfg_wr.data),
    .out_ready      (out_res.ready),
    .out_valid      (out_res.valid),
    .out_status     (out_res.status),
    .out_user_index (out_res.user_index)
  );

  // Checks
  `ASSERT_CLK(a_cmd_onehot, $onehot0({cmd.start, cmd.scan, cmd.commit, cmd.load_out}), "commands overlap")
  `ASSERT_CLK(a_busy_after_accept, (in_req.valid && in_ready) |=> !in_ready, "request taken while busy")
  `ASSERT_CLK(a_load_shows_result, cmd.load_out |=> out_res.valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== tb/tb_name_index_cache_with_expiry.sv =====
`timescale 1ns / 1ps

module tb_name_index_cache_with_expiry;
  import nic_pkg::*;

  // One request as it crosses the input channel
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KLO_W-1:0]  key_low;
    logic [KHI_W-1:0]  key_high;
    logic [TIME_W-1:0] now_ms;
    logic              dir_found;
    logic [UIDX_W-1:0] dir_index;
  } name_req_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [UIDX_W-1:0] user_index;
  } name_res_t;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NAME_POOL       = 24;
  localparam int RESET_CYCLES    = 10;
  // Request type the block does not define; answered with done
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  nic_in_if  in_if ();
  nic_out_if out_if ();
  nic_cfg_if cfg_if ();

  name_index_cache_with_expiry dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_if),
    .out_res(out_if),
    .cfg_wr (cfg_if)
  );

  // Shadow copy of the name table
  logic              shadow_valid [ENTRIES];
  logic [KLO_W-1:0]  shadow_key_low [ENTRIES];
  logic [KHI_W-1:0]  shadow_key_high [ENTRIES];
  logic [UIDX_W-1:0] shadow_user [ENTRIES];
  logic [TIME_W-1:0] shadow_stamp [ENTRIES];
  int unsigned       shadow_ptr;
  logic [TIME_W-1:0] timeout_ms;

  name_req_t name_requests [$];
  name_res_t lookups_due [$];
  int        err_count = 0;

  // Stimulus state
  logic [TIME_W-1:0] tick;
  logic [KLO_W-1:0]  pool_low [NAME_POOL];
  logic [KHI_W-1:0]  pool_high [NAME_POOL];

  // Apply one request to the shadow table and return the answer it gives
  function automatic name_res_t resolve_name(name_req_t r);
    name_res_t         res;
    logic [KLO_W-1:0]  klo;
    logic [KHI_W-1:0]  khi;
    logic [TIME_W-1:0] age;
    int                hit;
    int                n;
    int unsigned       p;
    res.status     = STAT_DONE;
    res.user_index = '0;
    klo = r.key_low & KEY_LOW_MASK;
    khi = r.key_high & KEY_HIGH_MASK;
    hit = -1;
    for (n = 0; n < ENTRIES; n++) begin
      if (hit < 0 && shadow_valid[n] && shadow_key_low[n] == klo &&
          shadow_key_high[n] == khi)
        hit = n;
    end
    case (r.req_type)
      REQ_ADD: begin
        if (hit >= 0) begin
          shadow_stamp[hit] = r.now_ms;
          res.status        = STAT_HIT;
          res.user_index    = shadow_user[hit];
        end else if (!r.dir_found) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          // first free slot after the pointer; full keeps the table as is
          res.status     = STAT_FULL;
          res.user_index = r.dir_index;
          p = shadow_ptr;
          for (n = 0; n < ENTRIES; n++) begin
            p = (p + 1) % ENTRIES;
            if (res.status == STAT_FULL && !shadow_valid[p]) begin
              shadow_valid[p]    = 1'b1;
              shadow_key_low[p]  = klo;
              shadow_key_high[p] = khi;
              shadow_user[p]     = r.dir_index;
              shadow_stamp[p]    = r.now_ms;
              shadow_ptr         = (shadow_ptr + 1) % ENTRIES;
              res.status         = STAT_INSERTED;
            end
          end
        end
      end
      REQ_DELETE: begin
        if (hit >= 0)
          shadow_valid[hit] = 1'b0;
      end
      REQ_EXPIRE: begin
        // wrapping age, cleared only when strictly past the timeout
        for (n = 0; n < ENTRIES; n++) begin
          age = r.now_ms - shadow_stamp[n];
          if (shadow_valid[n] && age > timeout_ms)
            shadow_valid[n] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [KLO_W-1:0] klo,
                           input logic [KHI_W-1:0] khi, input logic [TIME_W-1:0] stamp,
                           input logic found, input logic [UIDX_W-1:0] idx);
    name_req_t r;
    r.req_type  = kind;
    r.key_low   = klo;
    r.key_high  = khi;
    r.now_ms    = stamp;
    r.dir_found = found;
    r.dir_index = idx;
    name_requests.push_back(r);
  endtask

  // Fresh set of names: half printable padded names, half raw bits
  task automatic refill_pool();
    logic [8*KEY_BYTES-1:0] k;
    int                     i;
    int                     b;
    int                     len;
    for (i = 0; i < NAME_POOL; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        k = (8*KEY_BYTES)'({$urandom, $urandom, $urandom});
      end else begin
        k   = '0;
        len = $urandom_range(1, KEY_BYTES);
        for (b = 0; b < len; b++)
          k[8*b +: 8] = 8'($urandom_range(33, 126));
      end
      pool_low[i]  = k[KLO_W-1:0];
      pool_high[i] = k[KLO_W +: KHI_W];
    end
  endtask

  // Random traffic: mostly name lookups on the pool, with fill runs,
  // sweeps placed right at the timeout edge, and some raw noise
  task automatic gen_traffic(input int count);
    int                made;
    int                pick;
    int                len;
    int                j;
    int                k;
    int                op;
    int unsigned       step_max;
    logic [TIME_W-1:0] jump;
    made     = 0;
    step_max = (timeout_ms > 32'd60000) ? 30000 : timeout_ms / 2 + 2;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // fill run, enough adds to hit the full table
        len = $urandom_range(14, 20);
        for (j = 0; j < len; j++) begin
          tick += $urandom_range(0, step_max);
          k = $urandom_range(0, NAME_POOL - 1);
          queue_req(REQ_ADD, pool_low[k], pool_high[k], tick, 1'b1, UIDX_W'($urandom));
        end
        made += len;
      end else if (pick < 30) begin
        // touch one name, then sweep one tick either side of the timeout
        k = $urandom_range(0, NAME_POOL - 1);
        queue_req(REQ_ADD, pool_low[k], pool_high[k], tick, 1'b1, UIDX_W'($urandom));
        jump = timeout_ms - 32'd1 + $urandom_range(0, 2);
        tick += jump;
        queue_req(REQ_EXPIRE, {$urandom, $urandom}, KHI_W'($urandom), tick,
                  1'($urandom_range(0, 1)), UIDX_W'($urandom));
        made += 2;
      end else if (pick < 90) begin
        len = $urandom_range(4, 12);
        for (j = 0; j < len; j++) begin
          tick += $urandom_range(0, step_max);
          k  = $urandom_range(0, NAME_POOL - 1);
          op = $urandom_range(0, 99);
          if (op < 60)
            queue_req(REQ_ADD, pool_low[k], pool_high[k], tick,
                      $urandom_range(0, 99) < 85, UIDX_W'($urandom));
          else if (op < 85)
            queue_req(REQ_DELETE, pool_low[k], pool_high[k], tick,
                      1'($urandom_range(0, 1)), UIDX_W'($urandom));
          else if (op < 95)
            queue_req(REQ_EXPIRE, pool_low[k], pool_high[k], tick,
                      1'($urandom_range(0, 1)), UIDX_W'($urandom));
          else
            queue_req(REQ_UNUSED, pool_low[k], pool_high[k], tick,
                      1'($urandom_range(0, 1)), UIDX_W'($urandom));
        end
        made += len;
      end else begin
        len = $urandom_range(1, 3);
        for (j = 0; j < len; j++)
          queue_req(REQ_W'($urandom_range(0, 3)), {$urandom, $urandom}, KHI_W'($urandom),
                    $urandom, 1'($urandom_range(0, 1)), UIDX_W'($urandom));
        made += len;
      end
    end
  endtask

  // Block until no request is pending, in flight or owed a result
  task automatic wait_quiet();
    while (name_requests.size() != 0 || in_if.valid || lookups_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_expiry(input logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do
      @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    timeout_ms = value;
  endtask

  // Request driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    name_req_t taken;
    name_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.req_type  = in_if.req_type;
        taken.key_low   = in_if.key_low;
        taken.key_high  = in_if.key_high;
        taken.now_ms    = in_if.now_ms;
        taken.dir_found = in_if.dir_found;
        taken.dir_index = in_if.dir_index;
        lookups_due.push_back(resolve_name(taken));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (name_requests.size() != 0) begin
          nxt = name_requests.pop_front();
          in_if.req_type  <= nxt.req_type;
          in_if.key_low   <= nxt.key_low;
          in_if.key_high  <= nxt.key_high;
          in_if.now_ms    <= nxt.now_ms;
          in_if.dir_found <= nxt.dir_found;
          in_if.dir_index <= nxt.dir_index;
          in_if.valid     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; ready follows a rotating pattern that changes per stretch
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_div = 1;
  int          pat_step = 0;
  int          stretch_left = 0;

  always @(posedge clk) begin
    name_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lookups_due.size() == 0) begin
        $error("result with no request outstanding: status %0d, user_index %0d",
               out_if.status, out_if.user_index);
        err_count++;
      end else begin
        want = lookups_due.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          err_count++;
        end
        if (out_if.user_index !== want.user_index) begin
          $error("user_index: expected %0d, got %0d", want.user_index, out_if.user_index);
          err_count++;
        end
      end
    end
    if (stretch_left <= 0) begin
      stretch_left = $urandom_range(64, 400);
      pat_div      = $urandom_range(1, 4);
      if ($urandom_range(0, 2) == 0)
        ready_pat = 16'hFFFF;
      else
        ready_pat = 16'($urandom | (16'd1 << $urandom_range(0, 15)));
    end else begin
      stretch_left--;
    end
    pat_step++;
    if (pat_step >= pat_div) begin
      pat_step  = 0;
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
    out_if.ready <= rst_n ? ready_pat[0] : 1'b0;
  end

  // Watchdog: too long without any handshake
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] settings [5];
    int                counts [5];
    int                n;
    in_if.valid     = 1'b0;
    in_if.req_type  = REQ_ADD;
    in_if.key_low   = '0;
    in_if.key_high  = '0;
    in_if.now_ms    = '0;
    in_if.dir_found = 1'b0;
    in_if.dir_index = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    for (n = 0; n < ENTRIES; n++)
      shadow_valid[n] = 1'b0;
    shadow_ptr = 0;
    timeout_ms = EXPIRY_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: near the tick wrap so the timeout edge crosses zero
    t0 = 32'hFFFF_FF00;
    queue_req(REQ_ADD, 64'h41, 16'h0, t0, 1'b0, 16'h1111);      // unknown name
    queue_req(REQ_ADD, 64'h41, 16'h0, t0, 1'b1, 16'hFFFF);      // insert
    queue_req(REQ_ADD, 64'h41, 16'h0, t0, 1'b0, 16'h2222);      // hit, dir ignored
    queue_req(REQ_ADD, '1, '1, t0, 1'b1, 16'h0);                // all-ones key
    queue_req(REQ_ADD, '0, '0, t0, 1'b1, 16'h8001);             // all-zero key
    // same leading byte, nonzero byte after the zero padding
    queue_req(REQ_ADD, 64'h41, 16'h4200, t0, 1'b1, 16'h5555);
    queue_req(REQ_ADD, 64'h41, 16'h4200, t0, 1'b0, 16'h0);
    queue_req(REQ_DELETE, 64'h43, 16'h0, t0, 1'b0, 16'h0);      // delete, no match
    queue_req(REQ_DELETE, 64'h41, 16'h0, t0, 1'b0, 16'h0);
    queue_req(REQ_ADD, 64'h41, 16'h0, t0, 1'b0, 16'h0);
    queue_req(REQ_UNUSED, '1, '1, '1, 1'b1, '1);
    queue_req(REQ_ADD, 64'h41, 16'h0, t0 + 32'd10, 1'b1, 16'h00AA);
    // age equal to the timeout stays, one past it goes
    queue_req(REQ_EXPIRE, '0, '0, t0 + 32'd60000, 1'b0, 16'h0);
    queue_req(REQ_ADD, '0, '0, t0 + 32'd60000, 1'b0, 16'h0);
    queue_req(REQ_EXPIRE, '0, '0, t0 + 32'd60001, 1'b0, 16'h0);
    queue_req(REQ_ADD, 64'h41, 16'h4200, t0 + 32'd60001, 1'b0, 16'h0);
    queue_req(REQ_ADD, 64'h41, 16'h0, t0 + 32'd60001, 1'b0, 16'h0);
    queue_req(REQ_EXPIRE, '0, '0, t0 + 32'd60011, 1'b0, 16'h0);
    queue_req(REQ_ADD, 64'h41, 16'h0, t0 + 32'd60012, 1'b0, 16'h0);
    queue_req(REQ_DELETE, '1, '1, t0 + 32'd60012, 1'b1, '1);
    wait_quiet();

    // Random traffic at the reset timeout
    refill_pool();
    tick = $urandom;
    gen_traffic(400);

    // Then across several timeouts, extremes included
    settings[0] = 32'd1;
    counts[0]   = 300;
    settings[1] = 32'hFFFF_FFFF;
    counts[1]   = 300;
    settings[2] = 32'd0;
    counts[2]   = 250;
    settings[3] = $urandom_range(1000, 32'h4000_0000);
    counts[3]   = 400;
    settings[4] = $urandom_range(2, 50);
    counts[4]   = 300;
    for (n = 0; n < 5; n++) begin
      wait_quiet();
      write_expiry(settings[n]);
      refill_pool();
      tick = (n == 3) ? 32'hFFFF_0000 : $urandom;
      gen_traffic(counts[n]);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
